>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FFA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define FFA_ASSERT(name, clk, rst, prop, msg)
`define FFA_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/ffa_pkg.sv
// types, codes and default sizes for the first-fit block allocator
// no dependencies
package ffa_pkg;

  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_HEAP_BLOCKS = 4096;
  localparam int HEAP_REG_W      = 13;
  localparam int REQ_W           = 12;
  localparam int BLK_W           = 12;
  localparam int GRANT_MAX       = 4095;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE       = 2'd0,
    STAT_NO_FIT     = 2'd1,
    STAT_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_F_HDR,
    ST_F_LEN,
    ST_F_RD,
    ST_F_CHK,
    ST_F_DEC,
    ST_INS_RD,
    ST_INS_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] request_blocks;
    logic [BLK_W-1:0] free_block;
  } req_item_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] granted_block;
  } rsp_item_t;

endpackage

>>> hw/rtl/first_fit_block_allocator_top.sv
// First-fit block allocator. Free space is an address-ordered table of extents held in one
// ram with a single read and a single write port; a small sequencer walks it one entry at a
// time, reading and then checking each entry. An allocate searches for the first fit and,
// on an exact fit, closes the gap; a free searches for the position and then inserts or
// removes an entry, or merges with a neighbour. Headers live in a second ram of HEAP_BLOCKS
// entries. After reset the init state writes the first extent before the first item is
// taken. Configuration writes re-seed the table.
// depends on ffa_pkg, ffa_ram and assert_macros.svh
`include "assert_macros.svh"

module first_fit_block_allocator_top
  import ffa_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int HEAP_BLOCKS = DEF_HEAP_BLOCKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  req_item_t           req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rsp_item_t           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SW = $clog2(HEAP_BLOCKS);
  localparam int LW = $clog2(HEAP_BLOCKS + 1);
  localparam int XW = ((LW > HEAP_REG_W) ? LW : HEAP_REG_W) + 1;
  localparam int EW = SW + LW;

  state_t state, state_next;

  logic [HEAP_REG_W-1:0] heap_blocks;
  logic [CW-1:0]         extent_count;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         ins;
  logic [REQ_W-1:0]      req_blocks;
  logic [BLK_W-1:0]      blk;
  logic [XW-1:0]         flen;
  logic [XW-1:0]         prev_s, prev_l, next_s, next_l;
  logic                  has_next;
  status_t               res_status;
  logic [BLK_W-1:0]      res_grant;

  // ram ports
  logic          ext_we;
  logic [IW-1:0] ext_waddr, ext_raddr;
  logic [EW-1:0] ext_wdata, ext_rdata;
  logic          hdr_we;
  logic [SW-1:0] hdr_waddr, hdr_raddr;
  logic [LW-1:0] hdr_wdata, hdr_rdata;

  // configuration decode
  logic                  cfg_wr;
  logic [HEAP_REG_W-1:0] cfg_heap;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign cfg_heap = (32'(pwdata[HEAP_REG_W-1:0]) > 32'(HEAP_BLOCKS)) ?
                    HEAP_REG_W'(HEAP_BLOCKS) : pwdata[HEAP_REG_W-1:0];
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? PDATA_W'(heap_blocks) : '0;

  // shared compare and add terms
  logic [XW-1:0]   need, h, heap_x, rd_s, rd_l, hdr_len, prev_end, free_end;
  logic [CW:0]     pos_inc, count_x;
  logic            a_fit, a_exact, a_last, f_blk_bad, f_len_bad;
  logic            has_prev, f_ovl, f_jp, f_jn, f_full;

  assign need     = XW'(req_blocks) + XW'(1);
  assign h        = XW'(blk) - XW'(1);
  assign heap_x   = XW'(heap_blocks);
  assign rd_s     = XW'(ext_rdata[EW-1:LW]);
  assign rd_l     = XW'(ext_rdata[LW-1:0]);
  assign hdr_len  = XW'(hdr_rdata);
  assign pos_inc  = (CW+1)'(pos) + (CW+1)'(1);
  assign count_x  = (CW+1)'(extent_count);
  assign a_fit    = (rd_s < XW'(GRANT_MAX)) && (rd_l >= need);
  assign a_exact  = (rd_l == need);
  assign a_last   = (pos_inc >= count_x);
  assign f_blk_bad = (blk == '0) || (h >= heap_x);
  assign f_len_bad = (hdr_len == '0) || ((h + hdr_len) > heap_x);
  assign has_prev = (pos != '0);
  assign prev_end = prev_s + prev_l;
  assign free_end = h + flen;
  assign f_ovl    = (has_prev && (prev_end > h)) || (has_next && (free_end > next_s));
  assign f_jp     = has_prev && (prev_end == h);
  assign f_jn     = has_next && (free_end == next_s);
  assign f_full   = (count_x >= (CW+1)'(MAX_EXTENTS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          if (req.mode == MODE_FREE) begin
            state_next = ST_F_HDR;
          end else if (extent_count == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_A_RD;
          end
        end
      end
      ST_A_RD:   state_next = ST_A_CHK;
      ST_A_CHK: begin
        if (a_fit) begin
          state_next = a_exact ? ST_RM_RD : ST_DONE;
        end else begin
          state_next = a_last ? ST_DONE : ST_A_RD;
        end
      end
      ST_RM_RD:  state_next = (pos_inc < count_x) ? ST_RM_WR : ST_DONE;
      ST_RM_WR:  state_next = ST_RM_RD;
      ST_F_HDR:  state_next = f_blk_bad ? ST_DONE : ST_F_LEN;
      ST_F_LEN:  state_next = f_len_bad ? ST_DONE : ST_F_RD;
      ST_F_RD:   state_next = ((CW+1)'(pos) < count_x) ? ST_F_CHK : ST_F_DEC;
      ST_F_CHK:  state_next = (rd_s <= h) ? ST_F_RD : ST_F_DEC;
      ST_F_DEC: begin
        if (f_ovl) begin
          state_next = ST_DONE;
        end else if (f_jp && f_jn) begin
          state_next = ST_RM_RD;
        end else if (f_jp || f_jn || f_full) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_INS_RD;
        end
      end
      ST_INS_RD: state_next = (ins > pos) ? ST_INS_WR : ST_DONE;
      ST_INS_WR: state_next = ST_INS_RD;
      ST_DONE:   state_next = (!rsp_valid || rsp_ready) ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    ext_we    = 1'b0;
    ext_waddr = pos[IW-1:0];
    ext_wdata = ext_rdata;
    ext_raddr = pos[IW-1:0];
    hdr_we    = 1'b0;
    hdr_waddr = rd_s[SW-1:0];
    hdr_wdata = need[LW-1:0];
    hdr_raddr = h[SW-1:0];
    req_ready = (state == ST_IDLE);
    unique case (state)
      ST_INIT: begin
        ext_we    = 1'b1;
        ext_waddr = '0;
        ext_wdata = {SW'(0), LW'(heap_blocks)};
      end
      ST_A_CHK: begin
        if (a_fit) begin
          hdr_we = 1'b1;
          if (!a_exact) begin
            ext_we    = 1'b1;
            ext_wdata = {SW'(rd_s + need), LW'(rd_l - need)};
          end
        end
      end
      ST_RM_RD:  ext_raddr = pos_inc[IW-1:0];
      ST_RM_WR:  ext_we = 1'b1;
      ST_F_DEC: begin
        if (!f_ovl) begin
          if (f_jp) begin
            ext_we    = 1'b1;
            ext_waddr = IW'(pos - CW'(1));
            ext_wdata = {SW'(prev_s), LW'(prev_l + flen + (f_jn ? next_l : XW'(0)))};
          end else if (f_jn) begin
            ext_we    = 1'b1;
            ext_wdata = {SW'(h), LW'(next_l + flen)};
          end
        end
      end
      ST_INS_RD: begin
        ext_raddr = IW'(ins - CW'(1));
        if (!(ins > pos)) begin
          ext_we    = 1'b1;
          ext_wdata = {SW'(h), LW'(flen)};
        end
      end
      ST_INS_WR: begin
        ext_we    = 1'b1;
        ext_waddr = ins[IW-1:0];
      end
      default: ;
    endcase
    // a register write re-seeds the first extent
    if (cfg_wr) begin
      ext_we    = 1'b1;
      ext_waddr = '0;
      ext_wdata = {SW'(0), LW'(cfg_heap)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      heap_blocks  <= HEAP_REG_W'(HEAP_BLOCKS);
      extent_count <= CW'(1);
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_blocks <= req.request_blocks;
            blk        <= req.free_block;
            pos        <= '0;
            has_next   <= 1'b0;
            res_grant  <= '0;
            res_status <= (req.mode == MODE_ALLOC && extent_count == '0) ?
                          STAT_NO_FIT : STAT_DONE;
          end
        end
        ST_A_CHK: begin
          if (a_fit) begin
            res_grant <= BLK_W'(rd_s + XW'(1));
          end else begin
            pos <= pos + CW'(1);
            if (a_last) begin
              res_status <= STAT_NO_FIT;
            end
          end
        end
        ST_RM_RD: begin
          if (!(pos_inc < count_x)) begin
            extent_count <= extent_count - CW'(1);
          end
        end
        ST_RM_WR:  pos  <= pos + CW'(1);
        ST_F_LEN:  flen <= hdr_len;
        ST_F_CHK: begin
          if (rd_s <= h) begin
            prev_s <= rd_s;
            prev_l <= rd_l;
            pos    <= pos + CW'(1);
          end else begin
            next_s   <= rd_s;
            next_l   <= rd_l;
            has_next <= 1'b1;
          end
        end
        ST_F_DEC: begin
          ins <= extent_count;
          if (!f_ovl && !f_jp && !f_jn && f_full) begin
            res_status <= STAT_TABLE_FULL;
          end
        end
        ST_INS_RD: begin
          if (!(ins > pos)) begin
            extent_count <= extent_count + CW'(1);
          end
        end
        ST_INS_WR: ins <= ins - CW'(1);
        ST_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.granted_block <= res_grant;
          end
        end
        default: ;
      endcase
      if (cfg_wr) begin
        heap_blocks  <= cfg_heap;
        extent_count <= (cfg_heap == '0) ? CW'(0) : CW'(1);
      end
    end
  end

  ffa_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_extent_ram (
    .clk   (clk),
    .we    (ext_we),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  ffa_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_header_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  `FFA_ASSERT(a_count_bound, clk, rst, ((CW+1)'(extent_count) <= (CW+1)'(MAX_EXTENTS)), "extent count above table size")
  `FFA_ASSERT_IMPL(a_done_issues, clk, rst, (state == ST_DONE) && (!rsp_valid || rsp_ready), ##1 rsp_valid, "finished item not presented")
  `FFA_ASSERT_IMPL(a_fail_no_grant, clk, rst, rsp_valid && (rsp.status != STAT_DONE), rsp.granted_block == '0, "failed item carries a grant")

endmodule

>>> hw/rtl/ffa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sim/tb_top.sv
// self-checking testbench for first_fit_block_allocator_top: allocate and free items
// against a local first-fit extent table, heap size set through the apb port
// depends on ffa_pkg and the allocator rtl
module tb_top
  import ffa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEXT = DEF_MAX_EXTENTS;
  localparam int NHEAP = DEF_HEAP_BLOCKS;
  localparam logic [PADDR_W-1:0] ADDR_HEAP = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_item_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_item_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  first_fit_block_allocator_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // local copy of the allocator state
  logic [12:0] heap_size;
  logic [11:0] ext_start[NEXT];
  logic [12:0] ext_len[NEXT];
  int unsigned ext_count;
  logic [12:0] hdr_len[NHEAP];
  bit hdr_written[NHEAP];

  rsp_item_t pending_rsp[$];
  int unsigned live_grants[$];
  int unsigned old_grants[$];
  int errors = 0;
  bit calm = 1'b0;

  function automatic void table_seed();
    for (int i = 0; i < NEXT; i++) begin
      ext_start[i] = '0;
      ext_len[i] = '0;
    end
    ext_count = (heap_size == 0) ? 0 : 1;
    ext_len[0] = heap_size;
  endfunction

  function automatic void table_drop(int unsigned pos);
    for (int unsigned i = pos; i + 1 < ext_count; i++) begin
      ext_start[i] = ext_start[i+1];
      ext_len[i] = ext_len[i+1];
    end
    ext_count--;
    ext_start[ext_count] = '0;
    ext_len[ext_count] = '0;
  endfunction

  function automatic rsp_item_t carve(int unsigned want);
    rsp_item_t r;
    int unsigned need, s;
    r.status = STAT_NO_FIT;
    r.granted_block = '0;
    need = want + 1;
    for (int unsigned i = 0; i < ext_count; i++) begin
      s = ext_start[i];
      if (s + 1 > GRANT_MAX || ext_len[i] < need) continue;
      if (ext_len[i] == need) table_drop(i);
      else begin
        ext_start[i] = 12'(s + need);
        ext_len[i] = 13'(ext_len[i] - need);
      end
      hdr_len[s] = 13'(need);
      hdr_written[s] = 1'b1;
      r.status = STAT_DONE;
      r.granted_block = 12'(s + 1);
      return r;
    end
    return r;
  endfunction

  function automatic status_t give_back(int unsigned blk);
    int unsigned h, len, fin, p, prev_end;
    bit has_prev, has_next, join_prev, join_next;
    if (blk == 0) return STAT_DONE;
    h = blk - 1;
    if (h >= heap_size) return STAT_DONE;
    len = hdr_len[h];
    fin = h + len;
    if (len == 0 || fin > heap_size) return STAT_DONE;
    p = 0;
    while (p < ext_count && ext_start[p] <= h) p++;
    has_prev = p > 0;
    has_next = p < ext_count;
    prev_end = has_prev ? ext_start[p-1] + ext_len[p-1] : 0;
    // overlap with a free extent, e.g. a double free
    if (has_prev && prev_end > h) return STAT_DONE;
    if (has_next && fin > ext_start[p]) return STAT_DONE;
    join_prev = has_prev && prev_end == h;
    join_next = has_next && fin == ext_start[p];
    if (join_prev && join_next) begin
      ext_len[p-1] = 13'(ext_len[p-1] + len + ext_len[p]);
      table_drop(p);
    end else if (join_prev) begin
      ext_len[p-1] = 13'(ext_len[p-1] + len);
    end else if (join_next) begin
      ext_start[p] = 12'(h);
      ext_len[p] = 13'(ext_len[p] + len);
    end else begin
      if (ext_count >= NEXT) return STAT_TABLE_FULL;
      for (int unsigned i = ext_count; i > p; i--) begin
        ext_start[i] = ext_start[i-1];
        ext_len[i] = ext_len[i-1];
      end
      ext_start[p] = 12'(h);
      ext_len[p] = 13'(len);
      ext_count++;
    end
    return STAT_DONE;
  endfunction

  function automatic req_item_t mk_item(logic m, int unsigned want, int unsigned blk);
    req_item_t it;
    it.mode = m;
    it.request_blocks = 12'(want);
    it.free_block = 12'(blk);
    return it;
  endfunction

  // sends one item; valid stays high after acceptance so that a back-to-back item can follow
  task automatic send_item(req_item_t it);
    int gap;
    rsp_item_t r;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    if (it.mode == MODE_ALLOC) begin
      r = carve(it.request_blocks);
      if (r.status == STAT_DONE) live_grants.push_back(r.granted_block);
    end else begin
      r.status = give_back(it.free_block);
      r.granted_block = '0;
    end
    pending_rsp.push_back(r);
  endtask

  task automatic alloc(int unsigned want);
    send_item(mk_item(MODE_ALLOC, want, $urandom_range(0, 4095)));
  endtask

  task automatic free_blk(int unsigned blk);
    send_item(mk_item(MODE_FREE, $urandom_range(0, 4095), blk));
  endtask

  task automatic free_live(int idx);
    int unsigned g;
    g = live_grants[idx];
    live_grants.delete(idx);
    old_grants.push_back(g);
    free_blk(g);
  endtask

  // heap size writes only once the allocator has gone quiet
  task automatic set_heap(int unsigned v);
    @(posedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_HEAP;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    heap_size = (v[12:0] > NHEAP) ? 13'(NHEAP) : v[12:0];
    table_seed();
    foreach (live_grants[i]) old_grants.push_back(live_grants[i]);
    live_grants.delete();
  endtask

  // result checker with random stalls
  initial begin
    int w;
    rsp_item_t e;
    forever begin
      w = calm ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        rsp_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: status %0d grant %0d",
                                   rsp.status, rsp.granted_block);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status || rsp.granted_block !== e.granted_block) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected status %0d grant %0d, got status %0d grant %0d",
                     e.status, e.granted_block, rsp.status, rsp.granted_block);
        end
      end
    end
  end

  task automatic test_extremes();
    alloc(0);
    alloc(4095);
    alloc(7);
    free_blk(0);
    free_live(1);
    free_blk(live_grants[0]);
    free_live(0);
    free_blk(old_grants[0]);
    // unrepresentable grant: last extent starts at block 4095
    alloc(4094);
    alloc(0);
    free_live(0);
    alloc(4094);
    alloc(100);
  endtask

  task automatic test_heap_settings();
    set_heap(0);
    alloc(0);
    alloc(5);
    free_blk(0);
    set_heap(1);
    alloc(1);
    alloc(0);
    alloc(0);
    set_heap(8191);
    alloc(50);
    alloc(3);
    // shrink below existing headers: free past the end and header beyond the heap
    set_heap(30);
    free_blk(1);
    free_blk(53);
    free_blk(4095);
    alloc(28);
    set_heap(4096);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < 140; i++) alloc(0);
    for (int i = 0; i < 70; i++) free_live(i);
    while (live_grants.size() > 0) free_live($urandom_range(0, live_grants.size() - 1));
    alloc(4000);
  endtask

  task automatic test_random(int n);
    int r;
    int unsigned b;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 85 && live_grants.size() == 0)) begin
        if ($urandom_range(0, 9) == 0) alloc($urandom_range(0, 4095));
        else alloc($urandom_range(0, 40));
      end else if (r < 85) begin
        free_live($urandom_range(0, live_grants.size() - 1));
      end else begin
        b = $urandom_range(0, 4095);
        // a never-written header must not be read
        if (b != 0 && b - 1 < heap_size && !hdr_written[b-1])
          b = (old_grants.size() > 0) ? old_grants[$urandom_range(0, old_grants.size() - 1)] : 0;
        free_blk(b);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    heap_size = NHEAP;
    table_seed();
    foreach (hdr_written[i]) hdr_written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_heap_settings();
    test_table_full();
    test_random(500);
    set_heap($urandom_range(200, 1500));
    test_random(400);
    set_heap(4096);
    test_random(500);
    @(posedge clk);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_ram.sv
hw/rtl/first_fit_block_allocator_top.sv
sim/tb_top.sv
